/* hw/rtl/quaternion_product_rotate_unit_defines.svh */
// Assertion macros for the checker of the quaternion product and rotate unit.
`ifndef QUATERNION_PRODUCT_ROTATE_UNIT_DEFINES_SVH
`define QUATERNION_PRODUCT_ROTATE_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define QPR_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("qpr check failed");

// The condition must hold in the cycle after the trigger.
`define QPR_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("qpr check failed");

`endif

/* hw/rtl/qpr_pkg.sv */
// Shared constants and types of the quaternion product and rotate unit.
`timescale 1ns / 1ps

package qpr_pkg;

   // Default fixed-point format: Q2.14 in 16 bits.
   localparam int QPR_DATA_WIDTH = 16;
   localparam int QPR_FRAC_BITS  = 14;

   // Register stages from an accepted request beat to a response beat.
   localparam int QPR_PIPE_DEPTH = 6;

   // Sign map of one Hamilton-style product. Entry [k][j] set means that term j
   // of component k (w, x, y, z) is subtracted. Term j always multiplies left
   // component j by right component j xor k.
   typedef logic [3:0][3:0] qpr_neg_map_type;

   // Plain product a * b.
   localparam qpr_neg_map_type QPR_PROD_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

   // Product t * conj(a) with the conjugate folded into the signs.
   localparam qpr_neg_map_type QPR_CONJ_NEG = {4'b0011, 4'b1001, 4'b0101, 4'b0000};

endpackage

/* hw/rtl/qpr_stream_if.sv */
// Request and response channel interfaces of the quaternion product and rotate unit.
`timescale 1ns / 1ps

interface qpr_req_if
   import qpr_pkg::*;
#(
   parameter int DATA_WIDTH = QPR_DATA_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [DATA_WIDTH-1:0] a_w;
   logic signed [DATA_WIDTH-1:0] a_x;
   logic signed [DATA_WIDTH-1:0] a_y;
   logic signed [DATA_WIDTH-1:0] a_z;
   logic signed [DATA_WIDTH-1:0] b_w;
   logic signed [DATA_WIDTH-1:0] b_x;
   logic signed [DATA_WIDTH-1:0] b_y;
   logic signed [DATA_WIDTH-1:0] b_z;

   modport source (output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                   input ready);
   modport sink   (input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                   output ready);
endinterface

interface qpr_rsp_if
   import qpr_pkg::*;
#(
   parameter int DATA_WIDTH = QPR_DATA_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] r_w;
   logic signed [DATA_WIDTH-1:0] r_x;
   logic signed [DATA_WIDTH-1:0] r_y;
   logic signed [DATA_WIDTH-1:0] r_z;

   modport source (output valid, r_w, r_x, r_y, r_z, input ready);
   modport sink   (input valid, r_w, r_x, r_y, r_z, output ready);
endinterface

/* hw/rtl/qpr_hamilton.sv */
// Three-stage Hamilton product pipeline: multiply, sum, round and saturate.
`timescale 1ns / 1ps

module qpr_hamilton
   import qpr_pkg::*;
#(
   parameter int DATA_WIDTH = QPR_DATA_WIDTH,
   parameter int FRAC_BITS  = QPR_FRAC_BITS,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] lhs [4],
   input  logic signed [DATA_WIDTH-1:0] rhs [4],
   input  qpr_neg_map_type              neg_map,
   input  logic [SIDE_WIDTH-1:0]        side_in,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [DATA_WIDTH-1:0] res [4],
   output logic [SIDE_WIDTH-1:0]        side_out
);

   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (DATA_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   logic signed [PROD_W-1:0]     prod_in [4][4];
   logic signed [PROD_W-1:0]     prod1_ff [4][4];
   logic signed [SUM_W-1:0]      sum_in [4];
   logic signed [SUM_W-1:0]      sum2_ff [4];
   logic signed [DATA_WIDTH-1:0] res_in [4];
   logic signed [DATA_WIDTH-1:0] res3_ff [4];
   logic [SIDE_WIDTH-1:0]        side1_ff, side2_ff, side3_ff;

   // A stage takes a new beat when it is empty or its content moves on.
   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   genvar k, j;
   generate
      for (k = 0; k < 4; k++) begin : g_comp
         logic signed [SUM_W-1:0] rnd;
         logic signed [SUM_W-1:0] shf;

         for (j = 0; j < 4; j++) begin : g_term
            assign prod_in[k][j] = lhs[j] * rhs[j ^ k];
         end

         always_comb begin
            logic signed [SUM_W-1:0] acc;
            acc = '0;
            for (int t = 0; t < 4; t++) begin
               if (neg_map[k][t]) begin
                  acc = acc - SUM_W'(prod1_ff[k][t]);
               end else begin
                  acc = acc + SUM_W'(prod1_ff[k][t]);
               end
            end
            sum_in[k] = acc;
         end

         // Round half up, then clamp to the output range.
         assign rnd = sum2_ff[k] + HALF;
         assign shf = rnd >>> FRAC_BITS;

         always_comb begin
            if (shf > SAT_MAX) begin
               res_in[k] = SAT_MAX[DATA_WIDTH-1:0];
            end else if (shf < SAT_MIN) begin
               res_in[k] = SAT_MIN[DATA_WIDTH-1:0];
            end else begin
               res_in[k] = shf[DATA_WIDTH-1:0];
            end
         end

         assign res[k] = res3_ff[k];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         prod1_ff <= prod_in;
         side1_ff <= side_in;
      end
      if (adv2 && v1_ff) begin
         sum2_ff  <= sum_in;
         side2_ff <= side1_ff;
      end
      if (adv3 && v2_ff) begin
         res3_ff  <= res_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign side_out  = side3_ff;

endmodule

/* hw/rtl/quaternion_product_rotate_unit.sv */
// Top level of the quaternion product and vector rotate unit.
//
//   channel  direction  handshake          payload
//   req      in         req.valid/ready    command, a_w..a_z, b_w..b_z
//   rsp      out        rsp.valid/ready    r_w, r_x, r_y, r_z
//
// One request beat can be accepted every clock cycle while no stalled response
// backs up the stages; a response passes through two three-stage product
// pipelines in series (multiply, sum, round and saturate each take a register stage).
// Reset is synchronous and empties every stage; no clearing pass is needed.
// A stalled response holds its stage, and stages behind it keep filling, so
// up to six beats are in flight and none is dropped or repeated.
`timescale 1ns / 1ps

module quaternion_product_rotate_unit
   import qpr_pkg::*;
#(
   parameter int DATA_WIDTH = QPR_DATA_WIDTH,
   parameter int FRAC_BITS  = QPR_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   qpr_req_if.sink   req,
   qpr_rsp_if.source rsp
);

   localparam int SIDE_W = 1 + 4 * DATA_WIDTH;

   // First pass: a * b for the product command, a * (0, v) for the rotate
   // command. The operand a and the command ride along as side data.
   logic signed [DATA_WIDTH-1:0] lhs_a [4];
   logic signed [DATA_WIDTH-1:0] rhs_a [4];
   logic signed [DATA_WIDTH-1:0] t_res [4];
   logic [SIDE_W-1:0]            side_a_in, side_a_out;
   logic                         va_out, ra_out;

   // Second pass: t * conj(a). Its side data carries t and the command so the
   // product command can take its answer from the first pass.
   logic signed [DATA_WIDTH-1:0] a_q [4];
   logic signed [DATA_WIDTH-1:0] t_q [4];
   logic signed [DATA_WIDTH-1:0] r_res [4];
   logic [SIDE_W-1:0]            side_b_in, side_b_out;
   logic                         cmd_b;

   assign lhs_a[0] = req.a_w;
   assign lhs_a[1] = req.a_x;
   assign lhs_a[2] = req.a_y;
   assign lhs_a[3] = req.a_z;

   // The rotate command treats b as a pure vector.
   assign rhs_a[0] = req.command ? '0 : req.b_w;
   assign rhs_a[1] = req.b_x;
   assign rhs_a[2] = req.b_y;
   assign rhs_a[3] = req.b_z;

   assign side_a_in = {req.command, req.a_w, req.a_x, req.a_y, req.a_z};

   qpr_hamilton #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SIDE_WIDTH (SIDE_W)
   ) u_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .lhs       (lhs_a),
      .rhs       (rhs_a),
      .neg_map   (QPR_PROD_NEG),
      .side_in   (side_a_in),
      .out_valid (va_out),
      .out_ready (ra_out),
      .res       (t_res),
      .side_out  (side_a_out)
   );

   genvar i;
   generate
      for (i = 0; i < 4; i++) begin : g_unpack
         assign a_q[i] = side_a_out[(4 - i) * DATA_WIDTH - 1 -: DATA_WIDTH];
         assign t_q[i] = side_b_out[(4 - i) * DATA_WIDTH - 1 -: DATA_WIDTH];
      end
   endgenerate

   assign side_b_in = {side_a_out[SIDE_W-1], t_res[0], t_res[1], t_res[2], t_res[3]};

   qpr_hamilton #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SIDE_WIDTH (SIDE_W)
   ) u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (va_out),
      .in_ready  (ra_out),
      .lhs       (t_res),
      .rhs       (a_q),
      .neg_map   (QPR_CONJ_NEG),
      .side_in   (side_b_in),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .res       (r_res),
      .side_out  (side_b_out)
   );

   assign cmd_b = side_b_out[SIDE_W-1];

   // The rotate command returns the vector part of the second pass with a zero
   // real part; the product command returns the first pass unchanged.
   assign rsp.r_w = cmd_b ? '0       : t_q[0];
   assign rsp.r_x = cmd_b ? r_res[1] : t_q[1];
   assign rsp.r_y = cmd_b ? r_res[2] : t_q[2];
   assign rsp.r_z = cmd_b ? r_res[3] : t_q[3];

endmodule

/* hw/rtl/qpr_checker.sv */
// Port-level checker of the quaternion product and rotate unit, with its bind.
`timescale 1ns / 1ps
`include "quaternion_product_rotate_unit_defines.svh"

module qpr_checker
   import qpr_pkg::*;
#(
   parameter int DATA_WIDTH = QPR_DATA_WIDTH,
   parameter int DEPTH      = QPR_PIPE_DEPTH
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [4*DATA_WIDTH-1:0] rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Beats accepted but not yet delivered.
   always_comb begin
      cnt_in = cnt_ff;
      if (req_beat && !rsp_beat) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (rsp_beat && !req_beat) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `QPR_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `QPR_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `QPR_ASSERT_NOW(a_no_phantom_rsp, clock, reset, rsp_valid, cnt_ff != '0)
   `QPR_ASSERT_NOW(a_depth_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH))
   `QPR_ASSERT_NOW(a_empty_ready, clock, reset, cnt_ff == '0, req_ready)

endmodule

bind quaternion_product_rotate_unit qpr_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_qpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  ({rsp.r_w, rsp.r_x, rsp.r_y, rsp.r_z})
);
